// ===== rtl/core/oshof_pkg.sv =====
// ----------------------------------------------------------------------------
// oshof_pkg
// Shared types and constants of the object stream header offset finder.
// ----------------------------------------------------------------------------
package oshof_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned PAIR_W = 16;
  localparam int unsigned DEC_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Saturation limits of the byte position and pair counters
  localparam logic [POS_W-1:0]  POS_MAX  = 24'hFFFFFF;
  localparam logic [PAIR_W-1:0] PAIR_MAX = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_TOTAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_LENGTH = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_BAD_RANGE = 2'd2;

  typedef struct packed {
    logic [PAIR_W-1:0] object_total;
    logic [POS_W-1:0]  header_length;
    logic [POS_W-1:0]  stream_length;
  } cfg_t;

  // One finished pass: offsets are raw header values, header length not added
  typedef struct packed {
    logic [PAIR_W-1:0] wanted_index;
    logic [DEC_W-1:0]  start_raw;
    logic [DEC_W-1:0]  next_raw;
  } rec_t;

endpackage

// ===== rtl/core/oshof_front.sv =====
// ----------------------------------------------------------------------------
// oshof_front
// Per-byte header tokenizer: pairs tokens, accumulates decimal offsets and
// captures the wanted and following offsets; pushes a record on the last byte.
// ----------------------------------------------------------------------------
module oshof_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [7:0]                   data_byte,
  input  logic [oshof_pkg::PAIR_W-1:0] wanted_index,
  input  logic                         final_byte,
  input  oshof_pkg::cfg_t              cfg,
  output logic                         push,
  output oshof_pkg::rec_t              rec
);

  logic [oshof_pkg::POS_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic                         in_tok_r, in_tok_nxt;
  logic                         is_ofs_r, is_ofs_nxt;
  logic                         stopped_r, stopped_nxt;
  logic [oshof_pkg::PAIR_W-1:0] pair_cnt_r, pair_cnt_nxt;
  logic [oshof_pkg::DEC_W-1:0]  dec_val_r, dec_val_nxt;
  logic [oshof_pkg::PAIR_W-1:0] index_r, index_nxt;
  logic [oshof_pkg::DEC_W-1:0]  start_r, start_nxt;
  logic [oshof_pkg::DEC_W-1:0]  next_r, next_nxt;

  logic                         first;
  logic                         in_tok_c, is_ofs_c, stopped_c;
  logic [oshof_pkg::PAIR_W-1:0] pair_cnt_c, index_c;
  logic [oshof_pkg::DEC_W-1:0]  dec_val_c, start_c, next_c;
  logic                         is_space, is_digit;
  logic [35:0]                  mul10;

  always_comb begin
    first      = (byte_pos_r == '0);
    in_tok_c   = first ? 1'b0 : in_tok_r;
    is_ofs_c   = first ? 1'b0 : is_ofs_r;
    stopped_c  = first ? 1'b0 : stopped_r;
    pair_cnt_c = first ? '0 : pair_cnt_r;
    dec_val_c  = first ? '0 : dec_val_r;
    index_c    = first ? wanted_index : index_r;
    start_c    = first ? '0 : start_r;
    next_c     = first ? '0 : next_r;

    is_space = data_byte inside {8'h00, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20};
    is_digit = data_byte inside {[8'h30:8'h39]};

    in_tok_nxt   = in_tok_c;
    is_ofs_nxt   = is_ofs_c;
    stopped_nxt  = stopped_c;
    pair_cnt_nxt = pair_cnt_c;
    dec_val_nxt  = dec_val_c;
    index_nxt    = index_c;
    start_nxt    = start_c;
    next_nxt     = next_c;
    mul10        = '0;

    if (byte_pos_r < cfg.header_length) begin
      if (is_space) begin
        if (in_tok_c) begin
          if (is_ofs_c && pair_cnt_c < oshof_pkg::PAIR_MAX) begin
            pair_cnt_nxt = pair_cnt_c + 16'd1;
          end
          is_ofs_nxt = ~is_ofs_c;
          in_tok_nxt = 1'b0;
        end
      end else begin
        if (!in_tok_c) begin
          in_tok_nxt  = 1'b1;
          stopped_nxt = 1'b0;
          dec_val_nxt = '0;
        end
        if (is_ofs_c) begin
          if (!stopped_nxt) begin
            if (is_digit) begin
              mul10 = ({4'b0, dec_val_nxt} << 3) + ({4'b0, dec_val_nxt} << 1)
                    + {32'b0, data_byte[3:0]};
              if (|mul10[35:32]) begin
                dec_val_nxt = '0;
                stopped_nxt = 1'b1;
              end else begin
                dec_val_nxt = mul10[31:0];
              end
            end else begin
              stopped_nxt = 1'b1;
            end
          end
          if (pair_cnt_c < cfg.object_total) begin
            if (pair_cnt_c == index_c) begin
              start_nxt = dec_val_nxt;
            end
            if ({1'b0, pair_cnt_c} == {1'b0, index_c} + 17'd1) begin
              next_nxt = dec_val_nxt;
            end
          end
        end
      end
    end

    if (final_byte) begin
      byte_pos_nxt = '0;
    end else if (byte_pos_r < oshof_pkg::POS_MAX) begin
      byte_pos_nxt = byte_pos_r + 24'd1;
    end else begin
      byte_pos_nxt = byte_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      in_tok_r   <= 1'b0;
      is_ofs_r   <= 1'b0;
      stopped_r  <= 1'b0;
      pair_cnt_r <= '0;
      dec_val_r  <= '0;
      index_r    <= '0;
      start_r    <= '0;
      next_r     <= '0;
    end else if (accept) begin
      byte_pos_r <= byte_pos_nxt;
      in_tok_r   <= in_tok_nxt;
      is_ofs_r   <= is_ofs_nxt;
      stopped_r  <= stopped_nxt;
      pair_cnt_r <= pair_cnt_nxt;
      dec_val_r  <= dec_val_nxt;
      index_r    <= index_nxt;
      start_r    <= start_nxt;
      next_r     <= next_nxt;
    end
  end

  assign push             = accept & final_byte;
  assign rec.wanted_index = index_nxt;
  assign rec.start_raw    = start_nxt;
  assign rec.next_raw     = next_nxt;

endmodule

// ===== rtl/core/oshof_queue.sv =====
// ----------------------------------------------------------------------------
// oshof_queue
// Two-entry queue of finished pass records between front and back.
// ----------------------------------------------------------------------------
module oshof_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  oshof_pkg::rec_t push_rec,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output oshof_pkg::rec_t head
);

  oshof_pkg::rec_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            do_push, do_pop;

  always_comb begin
    do_push    = push & ~full;
    do_pop     = pop & not_empty;
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

endmodule

// ===== rtl/core/oshof_back.sv =====
// ----------------------------------------------------------------------------
// oshof_back
// Two-stage result pipeline: absolute positions, then range check, length
// and status into the output register.
// ----------------------------------------------------------------------------
module oshof_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rec_valid,
  input  oshof_pkg::rec_t             rec,
  input  oshof_pkg::cfg_t             cfg,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [oshof_pkg::POS_W-1:0] object_start,
  output logic [oshof_pkg::POS_W-1:0] object_length
);

  logic        a_valid_r, a_valid_nxt;
  logic [32:0] a_start_r, a_start_nxt;
  logic [32:0] a_end_r, a_end_nxt;
  logic        a_bad_r, a_bad_nxt;

  logic        o_valid_r, o_valid_nxt;
  logic [1:0]  o_status_r, o_status_nxt;
  logic [23:0] o_start_r, o_start_nxt;
  logic [23:0] o_len_r, o_len_nxt;

  logic        o_load, a_load;
  logic [32:0] sl33, diff;

  always_comb begin
    o_load = ~o_valid_r | out_ready;
    a_load = ~a_valid_r | o_load;
    pop    = a_load & rec_valid;

    a_valid_nxt = a_load ? rec_valid : a_valid_r;
    a_start_nxt = {9'b0, cfg.header_length} + {1'b0, rec.start_raw};
    if ({1'b0, rec.wanted_index} + 17'd1 < {1'b0, cfg.object_total}) begin
      a_end_nxt = {9'b0, cfg.header_length} + {1'b0, rec.next_raw};
    end else begin
      a_end_nxt = {9'b0, cfg.stream_length};
    end
    a_bad_nxt = (rec.wanted_index >= cfg.object_total);

    sl33 = {9'b0, cfg.stream_length};
    diff = a_end_r - a_start_r;
    o_valid_nxt = o_load ? a_valid_r : o_valid_r;
    if (a_bad_r) begin
      o_status_nxt = oshof_pkg::ST_BAD_INDEX;
      o_start_nxt  = '0;
      o_len_nxt    = '0;
    end else if (a_start_r >= sl33 || a_end_r > sl33) begin
      o_status_nxt = oshof_pkg::ST_BAD_RANGE;
      o_start_nxt  = '0;
      o_len_nxt    = '0;
    end else begin
      o_status_nxt = oshof_pkg::ST_OK;
      o_start_nxt  = a_start_r[23:0];
      o_len_nxt    = (a_end_r > a_start_r) ? diff[23:0] : 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_start_r <= a_start_nxt;
      a_end_r   <= a_end_nxt;
      a_bad_r   <= a_bad_nxt;
    end
    if (o_load) begin
      o_status_r <= o_status_nxt;
      o_start_r  <= o_start_nxt;
      o_len_r    <= o_len_nxt;
    end
  end

  assign out_valid     = o_valid_r;
  assign status        = o_status_r;
  assign object_start  = o_start_r;
  assign object_length = o_len_r;

endmodule

// ===== rtl/core/object_stream_header_offset_finder.sv =====
// ----------------------------------------------------------------------------
// object_stream_header_offset_finder
// Finds the start and length of one object from an object stream header.
//
// in_*  : one stream byte per transaction; in_tlast marks the last byte of a
//         pass. wanted_index is sampled on the first byte of each pass.
// out_* : one result per pass (status, object start, object length).
// cfg_* : register writes (object total, header length, stream length),
//         always ready; write only while the block is idle.
// Throughput: one byte per cycle while in_tready is high, passes may follow back to back.
// A result passes through the queue, the position stage and the output
// register after the last byte of its pass is taken.
// A two-entry queue decouples the byte front end from the result pipeline;
// a stalled out_tready drops in_tready only once the queue holds two
// results. Reset clears counters, state, valid flags and configuration, not
// stored records or result data; the first byte after reset starts a pass.
// ----------------------------------------------------------------------------
module object_stream_header_offset_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [23:8] wanted_index
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [1:0] status, [25:2] object_start,
                                  // [49:26] object_length, [55:50] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  oshof_pkg::cfg_t cfg_r, cfg_nxt;
  oshof_pkg::rec_t push_rec, head_rec;
  logic            accept, push, pop, q_full, q_valid;
  logic [1:0]      status;
  logic [23:0]     object_start, object_length;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        oshof_pkg::REG_OBJECT_TOTAL:  cfg_nxt.object_total  = cfg_data[15:0];
        oshof_pkg::REG_HEADER_LENGTH: cfg_nxt.header_length = cfg_data;
        oshof_pkg::REG_STREAM_LENGTH: cfg_nxt.stream_length = cfg_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_tready = ~q_full;
  assign accept    = in_tvalid & in_tready;

  oshof_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_tdata[7:0]),
    .wanted_index (in_tdata[23:8]),
    .final_byte   (in_tlast),
    .cfg          (cfg_r),
    .push         (push),
    .rec          (push_rec)
  );

  oshof_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_rec)
  );

  oshof_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_valid     (q_valid),
    .rec           (head_rec),
    .cfg           (cfg_r),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .status        (status),
    .object_start  (object_start),
    .object_length (object_length)
  );

  assign out_tdata = {6'b0, object_length, object_start, status};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for object_stream_header_offset_finder.
// A short table of hand-written passes comes first. Random passes follow:
// mostly well-formed headers with random offsets, some random noise bytes.
// The layout changes only while the block is idle. The result side is held
// off long enough to back up the byte input. Each result is checked against
// the table's expected result or the in-bench model of the offset lookup.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] start;
    logic [23:0] length;
  } locator_t;

  typedef logic [7:0] byte_q_t [$];

  typedef struct {
    bit          keep;
    logic [15:0] total;
    logic [23:0] hdr;
    logic [23:0] strm;
    string       text;
    logic [15:0] want;
    bit          typed;
    locator_t    loc;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = oshof_pkg::REG_OBJECT_TOTAL;
  logic [23:0] cfg_data = '0;

  // model copy of the registers and the scan state
  logic [15:0] total_m = '0;
  logic [23:0] hdr_m = '0;
  logic [23:0] strm_m = '0;
  logic [23:0] scan_pos = '0;
  bit          in_word = 1'b0;
  bit          at_offset = 1'b0;
  bit          digits_done = 1'b0;
  logic [15:0] pair_no = '0;
  logic [31:0] acc_val = '0;
  logic [15:0] asked = '0;
  logic [32:0] start_pos = '0;
  logic [32:0] next_pos = '0;

  locator_t    due_locs [$];
  locator_t    due;
  int          fault_count = 0;
  int          gap_pct = 37;
  int          stall_pct = 37;
  bit          hold_req = 1'b0;

  plan_row_t   pass_plan [7];
  int          gap_plan [4] = '{0, 86, 0, 37};
  int          stall_plan [4] = '{0, 0, 86, 37};

  object_stream_header_offset_finder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void locate_byte(input logic [7:0] c, input logic [15:0] w,
                                      input bit l, output bit got, output locator_t loc);
    logic [63:0] acc;
    logic [32:0] hit;
    logic [32:0] stop;
    got = 1'b0;
    loc = '0;
    if (scan_pos == 24'd0) begin
      asked = w;
      start_pos = {9'd0, hdr_m};
      next_pos = {9'd0, hdr_m};
      in_word = 1'b0;
      at_offset = 1'b0;
      digits_done = 1'b0;
      pair_no = '0;
      acc_val = '0;
    end
    if (scan_pos < hdr_m) begin
      if (c inside {8'h00, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20}) begin
        if (in_word) begin
          if (at_offset && pair_no != oshof_pkg::PAIR_MAX) pair_no++;
          at_offset = !at_offset;
          in_word = 1'b0;
        end
      end else begin
        if (!in_word) begin
          in_word = 1'b1;
          digits_done = 1'b0;
          acc_val = '0;
        end
        if (at_offset) begin
          if (!digits_done) begin
            if (c inside {[8'h30:8'h39]}) begin
              acc = 64'(acc_val) * 10 + 64'(c - 8'h30);
              if (acc > 64'hFFFF_FFFF) begin
                acc_val = '0;
                digits_done = 1'b1;
              end else begin
                acc_val = acc[31:0];
              end
            end else begin
              digits_done = 1'b1;
            end
          end
          if (pair_no < total_m) begin
            hit = {9'd0, hdr_m} + {1'b0, acc_val};
            if (pair_no == asked) start_pos = hit;
            if ({1'b0, pair_no} == {1'b0, asked} + 17'd1) next_pos = hit;
          end
        end
      end
    end
    if (scan_pos != oshof_pkg::POS_MAX) scan_pos++;
    if (l) begin
      scan_pos = '0;
      got = 1'b1;
      if (asked >= total_m) begin
        loc.status = oshof_pkg::ST_BAD_INDEX;
      end else begin
        stop = ({1'b0, asked} + 17'd1 < {1'b0, total_m}) ? next_pos : {9'd0, strm_m};
        if (start_pos >= {9'd0, strm_m} || stop > {9'd0, strm_m}) begin
          loc.status = oshof_pkg::ST_BAD_RANGE;
        end else begin
          loc.status = oshof_pkg::ST_OK;
          loc.start = start_pos[23:0];
          loc.length = (stop > start_pos) ? 24'(stop - start_pos) : 24'd0;
        end
      end
    end
  endfunction

  function automatic logic [7:0] blank();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0C;
      4: return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic byte_q_t offset_token(int span);
    byte_q_t    q;
    string      s;
    logic [7:0] junk;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 70) s = $sformatf("%0d", $urandom_range(span));
    else if (pick < 75) s = "4294967296";
    else if (pick < 80) s = "4294967295";
    else if (pick < 85)
      s = $sformatf("%0d%0d", $urandom_range(99999, 10000), $urandom_range(999999, 100000));
    else if (pick < 92) s = $sformatf("%s%0d", $urandom_range(1) ? "-" : "+", $urandom_range(span));
    else s = $sformatf("%0d", $urandom_range(span));
    for (int n = 0; n < s.len(); n++) q = {q, 8'(s[n])};
    if (pick >= 92) begin
      do junk = 8'($urandom_range(8'h21, 8'hFF)); while (junk inside {[8'h30:8'h39]});
      q = {q, junk};
      q = {q, 8'h30 + 8'($urandom_range(9))};
    end
    return q;
  endfunction

  function automatic byte_q_t header_pass(int npairs, int span, int hl);
    byte_q_t q;
    string   s;
    for (int p = 0; p < npairs; p++) begin
      if ($urandom_range(9) == 0) q = {q, blank()};
      s = ($urandom_range(19) == 0) ? "x-1" : $sformatf("%0d", p);
      for (int n = 0; n < s.len(); n++) q = {q, 8'(s[n])};
      repeat ($urandom_range(1, 2)) q = {q, blank()};
      q = {q, offset_token(span)};
      repeat ($urandom_range(1, 2)) q = {q, blank()};
    end
    if (hl <= 64) while (q.size() < hl) q = {q, blank()};
    repeat ($urandom_range(6)) q = {q, 8'($urandom)};
    if (q.size() == 0) q = {q, 8'($urandom)};
    return q;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic [15:0] w, input bit l,
                           input bit typed = 1'b0, input locator_t typed_loc = '0);
    bit       got;
    locator_t loc;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, b};
    in_tlast  <= l;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    locate_byte(b, w, l, got, loc);
    if (typed) loc = typed_loc;
    if (got) due_locs = {due_locs, loc};
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      oshof_pkg::REG_OBJECT_TOTAL:  total_m = val[15:0];
      oshof_pkg::REG_HEADER_LENGTH: hdr_m = val;
      oshof_pkg::REG_STREAM_LENGTH: strm_m = val;
      default: ;
    endcase
  endtask

  task automatic apply_layout(input logic [15:0] ot, input logic [23:0] hl,
                              input logic [23:0] sl);
    write_reg(oshof_pkg::REG_OBJECT_TOTAL, {8'd0, ot});
    write_reg(oshof_pkg::REG_HEADER_LENGTH, hl);
    write_reg(oshof_pkg::REG_STREAM_LENGTH, sl);
    cfg_valid <= 1'b0;
  endtask

  // drain all results, then give the pipeline time to empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_locs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_locs.size() == 0) begin
        $error("unexpected result transaction, out_tdata %h", out_tdata);
        fault_count++;
      end else begin
        due = due_locs.pop_front();
        if (out_tdata[1:0] !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_tdata[1:0]);
          fault_count++;
        end
        if (out_tdata[25:2] !== due.start) begin
          $error("object_start: expected %0d, got %0d", due.start, out_tdata[25:2]);
          fault_count++;
        end
        if (out_tdata[49:26] !== due.length) begin
          $error("object_length: expected %0d, got %0d", due.length, out_tdata[49:26]);
          fault_count++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int          r;
    int          i;
    int          ph;
    int          sent;
    int          span;
    int          tot_i;
    logic [7:0]  b;
    logic [15:0] total;
    logic [15:0] want;
    logic [23:0] hdr;
    logic [23:0] strm;
    byte_q_t     pass_q;

    // '@' stands for a 0x00 byte, '#' for 0xFF
    pass_plan = '{
      '{1'b1, 16'd0,     24'd0,  24'd0,       "#",             16'd0,
        1'b1, '{oshof_pkg::ST_BAD_INDEX, 24'd0, 24'd0}},
      '{1'b0, 16'd2,     24'd7,  24'd20,      "0 3 1 5",       16'd0,
        1'b1, '{oshof_pkg::ST_OK, 24'd10, 24'd2}},
      '{1'b0, 16'd1,     24'd13, 24'd50,      "0 4294967296@", 16'd0,
        1'b0, '0},
      '{1'b0, 16'hFFFF,  24'd0,  24'd0,       "@",             16'hFFFF,
        1'b1, '{oshof_pkg::ST_BAD_INDEX, 24'd0, 24'd0}},
      '{1'b0, 16'd3,     24'd4,  24'd10,      "0 1\n",         16'd2,
        1'b1, '{oshof_pkg::ST_OK, 24'd4, 24'd6}},
      '{1'b0, 16'd1,     24'd3,  24'd50,      "0 97",          16'd0,
        1'b1, '{oshof_pkg::ST_OK, 24'd12, 24'd38}},
      '{1'b0, 16'd2,     24'd9,  24'hFFFFFF,  "1\015-5\0142 3x", 16'd0,
        1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < 7; r++) begin
      if (!pass_plan[r].keep) begin
        settle();
        apply_layout(pass_plan[r].total, pass_plan[r].hdr, pass_plan[r].strm);
      end
      for (i = 0; i < pass_plan[r].text.len(); i++) begin
        b = pass_plan[r].text[i];
        if (b == "@") b = 8'h00;
        else if (b == "#") b = 8'hFF;
        push_byte(b, (i == 0) ? pass_plan[r].want : 16'($urandom),
                  i == pass_plan[r].text.len() - 1, pass_plan[r].typed, pass_plan[r].loc);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      gap_pct = gap_plan[ph];
      stall_pct = stall_plan[ph];
      if (ph == 0) begin
        // back-to-back one-byte passes against a stalled result side
        settle();
        apply_layout(16'd3, 24'd0, 24'd100);
        hold_req = 1'b1;
        repeat (24) push_byte(8'($urandom), 16'($urandom_range(4)), 1'b1);
      end
      sent = 0;
      while (sent < 220) begin
        settle();
        case ($urandom_range(9))
          0: total = 16'd0;
          1: total = 16'hFFFF;
          2: total = 16'($urandom);
          default: total = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(9))
          0: hdr = 24'd0;
          1: hdr = 24'hFFFFFF;
          2: hdr = 24'($urandom);
          default: hdr = 24'($urandom_range(8, 48));
        endcase
        case ($urandom_range(9))
          0: strm = 24'd0;
          1: strm = 24'hFFFFFF;
          2: strm = 24'($urandom);
          default: strm = 24'(hdr + $urandom_range(60));
        endcase
        apply_layout(total, hdr, strm);
        tot_i = total;
        span = (strm > hdr) ? int'(strm - hdr) + 4 : 20;
        if (span > 99999) span = 99999;
        repeat ($urandom_range(2, 6)) begin
          if ($urandom_range(99) < 15) begin
            pass_q.delete();
            repeat ($urandom_range(1, 12)) pass_q = {pass_q, 8'($urandom)};
          end else begin
            pass_q = header_pass($urandom_range((tot_i < 7) ? tot_i + 1 : 8), span, int'(hdr));
          end
          case ($urandom_range(7))
            0: want = 16'($urandom);
            1: want = total;
            2: want = 16'hFFFF;
            default: want = (tot_i != 0) ?
                            16'($urandom_range(((tot_i < 9) ? tot_i : 9) - 1)) : 16'd0;
          endcase
          for (i = 0; i < pass_q.size(); i++)
            push_byte(pass_q[i], (i == 0) ? want : 16'($urandom), i == pass_q.size() - 1);
          sent += pass_q.size();
        end
      end
    end

    settle();
    if (fault_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
